// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned URG_W    = 16;
  localparam int unsigned PAY_W    = 32;
  localparam int unsigned OCC_W    = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_e;

  typedef struct packed {
    logic [URG_W-1:0] urgency;
    logic [PAY_W-1:0] payload;
  } entry_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic             ins;    // qualified insert this cycle
    logic             rem;    // qualified remove this cycle
    logic [CNT_W-1:0] count;  // entries held before this word
    entry_t           ent;    // entry to insert
  } cell_ctrl_t;

endpackage

// File: rtl/spq_in_if.sv
// ----------------------------------------------------------------------------
// spq_in_if
// Command channel: valid/ready with command, urgency and payload.
// ----------------------------------------------------------------------------
interface spq_in_if;
  import spq_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       command;
  logic [URG_W-1:0] urgency;
  logic [PAY_W-1:0] payload;

  modport source (output valid, command, urgency, payload, input ready);
  modport sink   (input valid, command, urgency, payload, output ready);
endinterface

// File: rtl/spq_out_if.sv
// ----------------------------------------------------------------------------
// spq_out_if
// Result channel: valid/ready with status, removed entry and occupancy.
// ----------------------------------------------------------------------------
interface spq_out_if;
  import spq_pkg::*;

  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [URG_W-1:0] out_urgency;
  logic [PAY_W-1:0] out_payload;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, status, out_urgency, out_payload, occupancy, input ready);
  modport sink   (input valid, status, out_urgency, out_payload, occupancy, output ready);
endinterface

// File: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted array; shifts right on insert, left on remove.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
  input  logic             clk_i,
  input  logic [IDX_W-1:0] idx_i,        // slot position, tied off
  input  cell_ctrl_t       ctrl_i,
  input  entry_t           left_ent_i,   // neighbour towards the head
  input  logic             left_keep_i,
  input  entry_t           right_ent_i,  // neighbour towards the tail
  output entry_t           ent_o,
  output logic             keep_o        // stays put on this insert
);

  entry_t ent_q, ent_d;
  logic   occupied;

  assign occupied = CNT_W'(idx_i) < ctrl_i.count;
  // equal urgency stays ahead: new entry goes behind it
  assign keep_o   = occupied && (ent_q.urgency >= ctrl_i.ent.urgency);

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.ins && !keep_o) begin
      ent_d = left_keep_i ? ctrl_i.ent : left_ent_i;
    end else if (ctrl_i.rem) begin
      ent_d = right_ent_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// File: rtl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Stable max-priority queue built as a systolic row of sorted cells.
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  ---------+-----+-----------------------------------------------
//  req_i    | in  | command, urgency, payload
//  rsp_o    | out | status, out_urgency, out_payload, occupancy
//
//  One word per cycle unless rsp_o stalls: every cell compares against the
//  incoming urgency at once, so insert, remove and clear each finish in the
//  cycle of acceptance, and the result is registered in the cycle after.
//  Reset clears the count and the result valid flag; cell contents are left.
//  A stalled result holds req_i off only while rsp_o is full and not taken.
//  Unused command code 3 is accepted and gives no result.
// ----------------------------------------------------------------------------
module stable_priority_queue import spq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  spq_in_if.sink  req_i,
  spq_out_if.source rsp_o
);

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] count_q, count_d;
  logic             accept;
  logic             is_full, is_empty;
  cell_ctrl_t       ctrl;

  entry_t           cell_ent  [CAPACITY];
  logic             cell_keep [CAPACITY];

  logic             rsp_valid_q, rsp_valid_d;
  logic [2:0]       rsp_status_q, rsp_status_d;
  logic [URG_W-1:0] rsp_urg_q, rsp_urg_d;
  logic [PAY_W-1:0] rsp_pay_q, rsp_pay_d;

  // output register frees up in the cycle it is taken
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign is_full  = count_q == CNT_W'(CAPACITY);
  assign is_empty = count_q == '0;

  assign ctrl.ins         = accept && (req_i.command == CMD_INSERT) && !is_full;
  assign ctrl.rem         = accept && (req_i.command == CMD_REMOVE) && !is_empty;
  assign ctrl.count       = count_q;
  assign ctrl.ent.urgency = req_i.urgency;
  assign ctrl.ent.payload = req_i.payload;

  always_comb begin
    count_d      = count_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_urg_d    = rsp_urg_q;
    rsp_pay_d    = rsp_pay_q;
    if (accept) begin
      rsp_valid_d = 1'b1;
      rsp_urg_d   = '0;
      rsp_pay_d   = '0;
      case (req_i.command)
        CMD_INSERT: begin
          if (is_full) begin
            rsp_status_d = ST_FULL;
          end else begin
            rsp_status_d = ST_INSERTED;
            count_d      = count_q + CNT_W'(1);
          end
        end
        CMD_REMOVE: begin
          if (is_empty) begin
            rsp_status_d = ST_EMPTY;
          end else begin
            rsp_status_d = ST_REMOVED;
            rsp_urg_d    = cell_ent[0].urgency;  // head is always the winner
            rsp_pay_d    = cell_ent[0].payload;
            count_d      = count_q - CNT_W'(1);
          end
        end
        CMD_CLEAR: begin
          rsp_status_d = ST_CLEARED;
          count_d      = '0;
        end
        default: begin
          rsp_valid_d = rsp_valid_q && !rsp_o.ready;  // code 3: dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload of the result register, no reset needed
  always_ff @(posedge clk_i) begin
    rsp_status_q <= rsp_status_d;
    rsp_urg_q    <= rsp_urg_d;
    rsp_pay_q    <= rsp_pay_d;
  end

  // --------------------------------------------------------------------------
  // Cell row: slot 0 is the head, ordered by urgency then arrival
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_keep;

    if (i == 0) begin : g_head
      assign left_ent  = '0;
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_ent  = cell_ent[i-1];
      assign left_keep = cell_keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = cell_ent[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_W'(i)),
      .ctrl_i      (ctrl),
      .left_ent_i  (left_ent),
      .left_keep_i (left_keep),
      .right_ent_i (right_ent),
      .ent_o       (cell_ent[i]),
      .keep_o      (cell_keep[i])
    );
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.out_urgency = rsp_urg_q;
  assign rsp_o.out_payload = rsp_pay_q;
  assign rsp_o.occupancy   = OCC_W'(count_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> $stable(count_q) && rsp_o.valid)
    else $error("state moved while result stalled");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + CNT_W'(1)
                 && rsp_o.status == ST_INSERTED)
    else $error("insert did not grow queue");

  a_remove_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rem |=> rsp_o.valid && rsp_o.status == ST_REMOVED
                 && rsp_o.out_urgency == $past(cell_ent[0].urgency))
    else $error("remove did not return head");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.command == CMD_CLEAR |=> count_q == '0
                 && rsp_o.status == ST_CLEARED)
    else $error("clear left entries");

endmodule
